// ===== rtl/cpu_instruction_execute_core_assert.svh =====
// Assertion macros shared by the execute core RTL.
`ifndef CPU_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define CPU_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CIE_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CIE_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/cie_pkg.sv =====
// Shared types, codes and decode functions of the execute core.
package cie_pkg;

  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_NMI  = 2'd1;
  localparam logic [1:0] OP_IRQ  = 2'd2;

  localparam logic CFG_IRQ_VEC = 1'b0;
  localparam logic CFG_NMI_VEC = 1'b1;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h34;
  localparam logic [7:0] PUSH_BITS   = 8'h30;
  localparam logic [7:0] ONE_BIT     = 8'h20;

  typedef enum logic [5:0] {
    C_NOP, C_ADC, C_AND, C_ASL, C_ASA, C_BCC, C_BCS, C_BEQ, C_BIT, C_BMI, C_BNE, C_BPL,
    C_BRK, C_BVC, C_BVS, C_CLC, C_CLD, C_CLI, C_CLV, C_CMP, C_CPX, C_CPY, C_DEC, C_DEX,
    C_DEY, C_EOR, C_INC, C_INX, C_INY, C_JMP, C_JSR, C_LDA, C_LDX, C_LDY, C_LSR, C_LSA,
    C_ORA, C_PHA, C_PHP, C_PLA, C_PLP, C_ROL, C_ROA, C_ROR, C_RRA, C_RTI, C_RTS, C_SBC,
    C_SEC, C_SED, C_SEI, C_STA, C_STX, C_STY, C_TAX, C_TAY, C_TSX, C_TXA, C_TXS, C_TYA
  } cls_e;

  // Shift kinds
  localparam logic [1:0] SH_ASL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ROL = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  function automatic cls_e decode(input logic [7:0] opc);
    cls_e c;
    case (opc)
      8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: c = C_ADC;
      8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: c = C_SBC;
      8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: c = C_AND;
      8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: c = C_ORA;
      8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: c = C_EOR;
      8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: c = C_CMP;
      8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: c = C_LDA;
      8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D:        c = C_STA;
      8'h06, 8'h0E, 8'h16, 8'h1E: c = C_ASL;
      8'h26, 8'h2E, 8'h36, 8'h3E: c = C_ROL;
      8'h46, 8'h4E, 8'h56, 8'h5E: c = C_LSR;
      8'h66, 8'h6E, 8'h76, 8'h7E: c = C_ROR;
      8'hC6, 8'hCE, 8'hD6, 8'hDE: c = C_DEC;
      8'hE6, 8'hEE, 8'hF6, 8'hFE: c = C_INC;
      8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: c = C_LDY;
      8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: c = C_LDX;
      8'hC0, 8'hC4, 8'hCC: c = C_CPY;
      8'hE0, 8'hE4, 8'hEC: c = C_CPX;
      8'h84, 8'h8C, 8'h94: c = C_STY;
      8'h86, 8'h8E, 8'h96: c = C_STX;
      8'h24, 8'h2C: c = C_BIT;
      8'h4C, 8'h6C: c = C_JMP;
      8'h0A: c = C_ASA;
      8'h2A: c = C_ROA;
      8'h4A: c = C_LSA;
      8'h6A: c = C_RRA;
      8'h10: c = C_BPL;
      8'h30: c = C_BMI;
      8'h50: c = C_BVC;
      8'h70: c = C_BVS;
      8'h90: c = C_BCC;
      8'hB0: c = C_BCS;
      8'hD0: c = C_BNE;
      8'hF0: c = C_BEQ;
      8'h00: c = C_BRK;
      8'h20: c = C_JSR;
      8'h40: c = C_RTI;
      8'h60: c = C_RTS;
      8'h08: c = C_PHP;
      8'h28: c = C_PLP;
      8'h48: c = C_PHA;
      8'h68: c = C_PLA;
      8'h18: c = C_CLC;
      8'h38: c = C_SEC;
      8'h58: c = C_CLI;
      8'h78: c = C_SEI;
      8'hB8: c = C_CLV;
      8'hD8: c = C_CLD;
      8'hF8: c = C_SED;
      8'h88: c = C_DEY;
      8'hCA: c = C_DEX;
      8'hC8: c = C_INY;
      8'hE8: c = C_INX;
      8'h8A: c = C_TXA;
      8'h98: c = C_TYA;
      8'h9A: c = C_TXS;
      8'hA8: c = C_TAY;
      8'hAA: c = C_TAX;
      8'hBA: c = C_TSX;
      default: c = C_NOP;
    endcase
    return c;
  endfunction

  // N and Z from a result byte
  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    return {v[7], p[6:2], (v == 8'h00), p[0]};
  endfunction

  // {carry out, result}
  function automatic logic [8:0] shift_fn(input logic [1:0] kind, input logic [7:0] v,
                                          input logic cin);
    logic [8:0] r;
    case (kind)
      SH_ASL:  r = {v[7], v[6:0], 1'b0};
      SH_ROL:  r = {v[7], v[6:0], cin};
      SH_LSR:  r = {v[0], 1'b0, v[7:1]};
      SH_ROR:  r = {v[0], cin, v[7:1]};
      default: r = {1'b0, v};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cie_req_if.sv =====
// Request channel of the execute core: one item per handshake.
interface cie_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  opcode;
  logic [7:0]  operand;
  logic [15:0] target_address;
  logic [15:0] next_pc;
  logic        irq_line;

  modport source (output valid, operation, opcode, operand, target_address, next_pc,
                  irq_line, input ready);
  modport sink   (input valid, operation, opcode, operand, target_address, next_pc,
                  irq_line, output ready);
endinterface

// ===== rtl/cie_rsp_if.sv =====
// Result channel of the execute core: register values, write request, next pc.
interface cie_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc;
  logic [7:0]  accumulator;
  logic [7:0]  x_index;
  logic [7:0]  y_index;
  logic [7:0]  stack_pointer;
  logic [7:0]  status;
  logic        write_enable;
  logic [7:0]  write_data;
  logic        interrupt_taken;

  modport source (output valid, pc, accumulator, x_index, y_index, stack_pointer, status,
                  write_enable, write_data, interrupt_taken, input ready);
  modport sink   (input valid, pc, accumulator, x_index, y_index, stack_pointer, status,
                  write_enable, write_data, interrupt_taken, output ready);
endinterface

// ===== rtl/cpu_instruction_execute_core.sv =====
// Top level of the 6502-style execute core with its private stack page memory.
//
// Executes one request per item: an instruction (opcode, fetched operand, target
// address, next pc), an NMI entry or an IRQ entry. A, X, Y, SP, P and the IRQ
// delay bit live in flops; the stack page is a 256x8 single-port synchronous RAM
// (one read or one write per cycle, registered read data) with a per-entry valid
// bit so unwritten bytes read as zero right after reset, with no clearing pass.
// Throughput is set by that one RAM port:
//   - items with no stack access: one request per cycle while the output is free;
//   - pushes (PHA, PHP, JSR, BRK, NMI/IRQ entry): the first byte is written and the
//     result registered when the request is taken; later bytes drain in ST_PUSH
//     while the input is held off;
//   - pulls (PLA, PLP, RTS, RTI): one read per cycle in ST_PULL, then ST_FIN
//     finishes the flags / pc and shows the result once the output is free.
// The result sits in a single output register; a new request is taken only while
// it is empty or its result is taken. Vectors are written on the cfg port (index 0
// IRQ/BRK, 1 NMI); the user must do so only while the core is idle (unenforced).
module cpu_instruction_execute_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  cie_req_if.sink          req_i,
  cie_rsp_if.source        rsp_o
);

  `include "cpu_instruction_execute_core_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_PULL = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // architectural state
  logic [7:0]  acc_q, acc_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d;
  logic        dly_q, dly_d;
  logic [15:0] irq_vec_q, nmi_vec_q;

  // sequencer
  logic [1:0]  st_q, st_d;
  logic [1:0]  cnt_q, cnt_d;         // push: bytes left; pull: reads issued
  logic [1:0]  pull_n_q, pull_n_d;
  logic [7:0]  base_q, base_d;       // stack pointer before pull / next push address
  logic [7:0]  push_q [2];
  logic [7:0]  push_d [2];
  logic [7:0]  pb_q [3];             // pulled bytes
  logic [7:0]  pb_d [3];
  cie_pkg::cls_e cls_q, cls_d;
  logic        line_q, line_d;
  logic [15:0] np_q, np_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_pc_q, out_pc_d;
  logic [7:0]  out_acc_q, out_acc_d, out_x_q, out_x_d, out_y_q, out_y_d;
  logic [7:0]  out_sp_q, out_sp_d, out_p_q, out_p_d, out_wd_q, out_wd_d;
  logic        out_we_q, out_we_d, out_tk_q, out_tk_d;

  // stack RAM
  logic [7:0]  mem [256];
  logic [255:0] vld_q;
  logic        mem_we, mem_re;
  logic [7:0]  mem_addr, mem_wdata;
  logic [7:0]  rd_data_q;
  logic        rd_vld_q;
  logic [7:0]  rd_byte;

  // datapath temporaries
  logic        in_acc, out_free, emit;
  cie_pkg::cls_e cls;
  logic [15:0] pc_w, ret_w;
  logic        we_w, tk_w;
  logic [7:0]  wd_w, pb0, pb1, pb2, addv, cmp_reg, nf;
  logic [1:0]  npush, npull;
  logic [8:0]  sum9, sh9, dif9;
  logic [1:0]  sh_kind;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (st_q == ST_IDLE) && out_free;
  assign in_acc      = req_i.valid && req_i.ready;
  assign rd_byte     = rd_vld_q ? rd_data_q : 8'h00;
  assign cls         = cie_pkg::decode(req_i.opcode);

  // shared ALU pieces
  assign addv    = (cls == cie_pkg::C_SBC) ? ~req_i.operand : req_i.operand;
  assign sum9    = {1'b0, acc_q} + {1'b0, addv} + {8'h00, p_q[0]};
  assign cmp_reg = (cls == cie_pkg::C_CPX) ? x_q : ((cls == cie_pkg::C_CPY) ? y_q : acc_q);
  assign dif9    = {1'b0, cmp_reg} - {1'b0, req_i.operand};

  always_comb begin
    case (cls)
      cie_pkg::C_LSR, cie_pkg::C_LSA: sh_kind = cie_pkg::SH_LSR;
      cie_pkg::C_ROL, cie_pkg::C_ROA: sh_kind = cie_pkg::SH_ROL;
      cie_pkg::C_ROR, cie_pkg::C_RRA: sh_kind = cie_pkg::SH_ROR;
      default:                        sh_kind = cie_pkg::SH_ASL;
    endcase
  end

  // accumulator forms shift A, memory forms shift the operand
  assign sh9 = cie_pkg::shift_fn(sh_kind,
      (cls == cie_pkg::C_ASA || cls == cie_pkg::C_LSA || cls == cie_pkg::C_ROA ||
       cls == cie_pkg::C_RRA) ? acc_q : req_i.operand, p_q[0]);

  always_comb begin
    acc_d = acc_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q; dly_d = dly_q;
    st_d = st_q; cnt_d = cnt_q; pull_n_d = pull_n_q; base_d = base_q;
    push_d = push_q; pb_d = pb_q; cls_d = cls_q; line_d = line_q; np_d = np_q;
    mem_we = 1'b0; mem_re = 1'b0; mem_addr = base_q; mem_wdata = push_q[0];
    pc_w = np_q; we_w = 1'b0; wd_w = 8'h00; tk_w = 1'b0;
    pb0 = 8'h00; pb1 = 8'h00; pb2 = 8'h00; npush = 2'd0; npull = 2'd0;
    ret_w = 16'h0000; nf = 8'h00;
    emit = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          pc_w = req_i.next_pc;
          if (req_i.operation == cie_pkg::OP_NMI) begin
            pb0 = req_i.next_pc[15:8]; pb1 = req_i.next_pc[7:0]; pb2 = p_q; npush = 2'd3;
            p_d = p_q | 8'h04; pc_w = nmi_vec_q; tk_w = 1'b1; dly_d = 1'b0;
          end else if (req_i.operation == cie_pkg::OP_IRQ) begin
            // a change of I by the last instruction is seen one item late
            if (dly_q == p_q[2]) begin
              pb0 = req_i.next_pc[15:8]; pb1 = req_i.next_pc[7:0]; pb2 = p_q; npush = 2'd3;
              p_d = p_q | 8'h04; pc_w = irq_vec_q; tk_w = 1'b1;
            end
            dly_d = 1'b0;
          end else if (req_i.operation == cie_pkg::OP_EXEC) begin
            dly_d = 1'b0;
            case (cls)
              cie_pkg::C_ADC, cie_pkg::C_SBC: begin
                acc_d = sum9[7:0];
                p_d = cie_pkg::set_nz({1'b0,
                        ((acc_q[7] ^ sum9[7]) & (addv[7] ^ sum9[7])),
                        p_q[5:1], sum9[8]}, sum9[7:0]);
              end
              cie_pkg::C_AND: begin
                acc_d = acc_q & req_i.operand; p_d = cie_pkg::set_nz(p_q, acc_d);
              end
              cie_pkg::C_ORA: begin
                acc_d = acc_q | req_i.operand; p_d = cie_pkg::set_nz(p_q, acc_d);
              end
              cie_pkg::C_EOR: begin
                acc_d = acc_q ^ req_i.operand; p_d = cie_pkg::set_nz(p_q, acc_d);
              end
              cie_pkg::C_ASL, cie_pkg::C_LSR, cie_pkg::C_ROL, cie_pkg::C_ROR: begin
                we_w = 1'b1; wd_w = sh9[7:0];
                p_d = cie_pkg::set_nz({p_q[7:1], sh9[8]}, sh9[7:0]);
              end
              cie_pkg::C_ASA, cie_pkg::C_LSA, cie_pkg::C_ROA, cie_pkg::C_RRA: begin
                acc_d = sh9[7:0];
                p_d = cie_pkg::set_nz({p_q[7:1], sh9[8]}, sh9[7:0]);
              end
              cie_pkg::C_BIT: begin
                p_d = {req_i.operand[7:6], p_q[5:2],
                       ((acc_q & req_i.operand) == 8'h00), p_q[0]};
              end
              cie_pkg::C_BCC: if (!p_q[0]) pc_w = req_i.target_address;
              cie_pkg::C_BCS: if (p_q[0])  pc_w = req_i.target_address;
              cie_pkg::C_BNE: if (!p_q[1]) pc_w = req_i.target_address;
              cie_pkg::C_BEQ: if (p_q[1])  pc_w = req_i.target_address;
              cie_pkg::C_BVC: if (!p_q[6]) pc_w = req_i.target_address;
              cie_pkg::C_BVS: if (p_q[6])  pc_w = req_i.target_address;
              cie_pkg::C_BPL: if (!p_q[7]) pc_w = req_i.target_address;
              cie_pkg::C_BMI: if (p_q[7])  pc_w = req_i.target_address;
              cie_pkg::C_BRK: begin
                ret_w = req_i.next_pc + 16'd1;
                pb0 = ret_w[15:8]; pb1 = ret_w[7:0]; pb2 = p_q | cie_pkg::PUSH_BITS;
                npush = 2'd3; pc_w = irq_vec_q; p_d = p_q | 8'h04;
              end
              cie_pkg::C_CLC: p_d = p_q & 8'hFE;
              cie_pkg::C_SEC: p_d = p_q | 8'h01;
              cie_pkg::C_CLD: p_d = p_q & 8'hF7;
              cie_pkg::C_SED: p_d = p_q | 8'h08;
              cie_pkg::C_CLV: p_d = p_q & 8'hBF;
              cie_pkg::C_CLI: if (p_q[2]) begin
                p_d = p_q & 8'hFB; dly_d = req_i.irq_line;
              end
              cie_pkg::C_SEI: if (!p_q[2]) begin
                p_d = p_q | 8'h04; dly_d = req_i.irq_line;
              end
              cie_pkg::C_CMP, cie_pkg::C_CPX, cie_pkg::C_CPY:
                p_d = cie_pkg::set_nz({p_q[7:1], !dif9[8]}, dif9[7:0]);
              cie_pkg::C_DEC: begin
                we_w = 1'b1; wd_w = req_i.operand - 8'd1; p_d = cie_pkg::set_nz(p_q, wd_w);
              end
              cie_pkg::C_INC: begin
                we_w = 1'b1; wd_w = req_i.operand + 8'd1; p_d = cie_pkg::set_nz(p_q, wd_w);
              end
              cie_pkg::C_DEX: begin x_d = x_q - 8'd1; p_d = cie_pkg::set_nz(p_q, x_d); end
              cie_pkg::C_DEY: begin y_d = y_q - 8'd1; p_d = cie_pkg::set_nz(p_q, y_d); end
              cie_pkg::C_INX: begin x_d = x_q + 8'd1; p_d = cie_pkg::set_nz(p_q, x_d); end
              cie_pkg::C_INY: begin y_d = y_q + 8'd1; p_d = cie_pkg::set_nz(p_q, y_d); end
              cie_pkg::C_JMP: pc_w = req_i.target_address;
              cie_pkg::C_JSR: begin
                ret_w = req_i.next_pc - 16'd1;
                pb0 = ret_w[15:8]; pb1 = ret_w[7:0]; npush = 2'd2;
                pc_w = req_i.target_address;
              end
              cie_pkg::C_RTS: npull = 2'd2;
              cie_pkg::C_RTI: npull = 2'd3;
              cie_pkg::C_PLA, cie_pkg::C_PLP: npull = 2'd1;
              cie_pkg::C_LDA: begin
                acc_d = req_i.operand; p_d = cie_pkg::set_nz(p_q, req_i.operand);
              end
              cie_pkg::C_LDX: begin
                x_d = req_i.operand; p_d = cie_pkg::set_nz(p_q, req_i.operand);
              end
              cie_pkg::C_LDY: begin
                y_d = req_i.operand; p_d = cie_pkg::set_nz(p_q, req_i.operand);
              end
              cie_pkg::C_PHA: begin pb0 = acc_q; npush = 2'd1; end
              cie_pkg::C_PHP: begin pb0 = p_q | cie_pkg::PUSH_BITS; npush = 2'd1; end
              cie_pkg::C_STA: begin we_w = 1'b1; wd_w = acc_q; end
              cie_pkg::C_STX: begin we_w = 1'b1; wd_w = x_q; end
              cie_pkg::C_STY: begin we_w = 1'b1; wd_w = y_q; end
              cie_pkg::C_TAX: begin x_d = acc_q; p_d = cie_pkg::set_nz(p_q, acc_q); end
              cie_pkg::C_TAY: begin y_d = acc_q; p_d = cie_pkg::set_nz(p_q, acc_q); end
              cie_pkg::C_TSX: begin x_d = sp_q; p_d = cie_pkg::set_nz(p_q, sp_q); end
              cie_pkg::C_TXA: begin acc_d = x_q; p_d = cie_pkg::set_nz(p_q, x_q); end
              cie_pkg::C_TYA: begin acc_d = y_q; p_d = cie_pkg::set_nz(p_q, y_q); end
              cie_pkg::C_TXS: sp_d = x_q;
              default: ;
            endcase
          end

          if (npush != 2'd0) begin
            // first byte goes out now, the rest drain in ST_PUSH
            mem_we = 1'b1; mem_addr = sp_q; mem_wdata = pb0;
            push_d[0] = pb1; push_d[1] = pb2;
            base_d = sp_q - 8'd1;
            sp_d = sp_q - {6'd0, npush};
            cnt_d = npush - 2'd1;
            st_d = (npush == 2'd1) ? ST_IDLE : ST_PUSH;
            emit = 1'b1;
          end else if (npull != 2'd0) begin
            mem_re = 1'b1; mem_addr = sp_q + 8'd1;
            base_d = sp_q; sp_d = sp_q + {6'd0, npull};
            cnt_d = 2'd1; pull_n_d = npull; st_d = ST_PULL;
            cls_d = cls; line_d = req_i.irq_line; np_d = req_i.next_pc;
          end else begin
            emit = 1'b1;
          end
        end
      end

      ST_PUSH: begin
        mem_we = 1'b1; mem_addr = base_q; mem_wdata = push_q[0];
        push_d[0] = push_q[1];
        base_d = base_q - 8'd1;
        cnt_d = cnt_q - 2'd1;
        if (cnt_q == 2'd1) st_d = ST_IDLE;
      end

      ST_PULL: begin
        pb_d[cnt_q - 2'd1] = rd_byte;
        if (cnt_q == pull_n_q) begin
          st_d = ST_FIN;
        end else begin
          mem_re = 1'b1; mem_addr = base_q + {6'd0, cnt_q} + 8'd1;
          cnt_d = cnt_q + 2'd1;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          emit = 1'b1; st_d = ST_IDLE;
          case (cls_q)
            cie_pkg::C_PLA: begin acc_d = pb_q[0]; p_d = cie_pkg::set_nz(p_q, pb_q[0]); end
            cie_pkg::C_PLP: begin
              nf = pb_q[0] | cie_pkg::ONE_BIT;
              if (nf[2] != p_q[2]) dly_d = line_q;
              p_d = nf;
            end
            cie_pkg::C_RTS: pc_w = {pb_q[1], pb_q[0]} + 16'd1;
            cie_pkg::C_RTI: begin
              p_d = pb_q[0] | cie_pkg::ONE_BIT; pc_w = {pb_q[2], pb_q[1]};
            end
            default: ;
          endcase
        end
      end

      default: st_d = ST_IDLE;
    endcase

    out_valid_d = (out_valid_q && !rsp_o.ready) || emit;
    out_pc_d = out_pc_q; out_acc_d = out_acc_q; out_x_d = out_x_q; out_y_d = out_y_q;
    out_sp_d = out_sp_q; out_p_d = out_p_q; out_we_d = out_we_q; out_wd_d = out_wd_q;
    out_tk_d = out_tk_q;
    if (emit) begin
      out_pc_d = pc_w; out_acc_d = acc_d; out_x_d = x_d; out_y_d = y_d;
      out_sp_d = sp_d; out_p_d = p_d; out_we_d = we_w; out_wd_d = wd_w; out_tk_d = tk_w;
    end
  end

  // control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 8'h00; x_q <= 8'h00; y_q <= 8'h00;
      sp_q <= cie_pkg::SP_RESET; p_q <= cie_pkg::FLAGS_RESET; dly_q <= 1'b0;
      irq_vec_q <= 16'h0000; nmi_vec_q <= 16'h0000;
      st_q <= ST_IDLE; cnt_q <= 2'd0; pull_n_q <= 2'd0;
      out_valid_q <= 1'b0;
      vld_q <= '0; rd_vld_q <= 1'b0;
    end else begin
      acc_q <= acc_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d; dly_q <= dly_d;
      st_q <= st_d; cnt_q <= cnt_d; pull_n_q <= pull_n_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cie_pkg::CFG_IRQ_VEC: irq_vec_q <= cfg_data_i;
          cie_pkg::CFG_NMI_VEC: nmi_vec_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (mem_we) vld_q[mem_addr] <= 1'b1;
      if (mem_re) rd_vld_q <= vld_q[mem_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q <= base_d; push_q <= push_d; pb_q <= pb_d;
    cls_q <= cls_d; line_q <= line_d; np_q <= np_d;
    out_pc_q <= out_pc_d; out_acc_q <= out_acc_d; out_x_q <= out_x_d; out_y_q <= out_y_d;
    out_sp_q <= out_sp_d; out_p_q <= out_p_d; out_we_q <= out_we_d; out_wd_q <= out_wd_d;
    out_tk_q <= out_tk_d;
  end

  // stack page RAM, single port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem[mem_addr];
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.pc              = out_pc_q;
  assign rsp_o.accumulator     = out_acc_q;
  assign rsp_o.x_index         = out_x_q;
  assign rsp_o.y_index         = out_y_q;
  assign rsp_o.stack_pointer   = out_sp_q;
  assign rsp_o.status          = out_p_q;
  assign rsp_o.write_enable    = out_we_q;
  assign rsp_o.write_data      = out_wd_q;
  assign rsp_o.interrupt_taken = out_tk_q;

  `CIE_ASSERT_IMP(a_one_port, mem_we, !mem_re, "stack RAM read and write in one cycle")
  `CIE_ASSERT_NXT(a_sp_at_accept, !in_acc, $stable(sp_q), "SP moved outside an accept")
  `CIE_ASSERT_NXT(a_push_done, (st_q == ST_PUSH) && (cnt_q == 2'd1), st_q == ST_IDLE,
                  "push drain overran")
  `CIE_ASSERT_NXT(a_fin_emits, (st_q == ST_FIN) && out_free, out_valid_q,
                  "pull finish gave no result")

endmodule

// ===== sim/tb_top.sv =====
// Testbench of the execute core: directed table, then random instruction streams.
module tb_top;
  import cie_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  cie_req_if req_i ();
  cie_rsp_if rsp_o ();

  cpu_instruction_execute_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req_i(req_i.sink), .rsp_o(rsp_o.source)
  );

  // One request item and one result item, as the ports carry them.
  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  opcode;
    logic [7:0]  operand;
    logic [15:0] target_address;
    logic [15:0] next_pc;
    logic        irq_line;
  } cpu_req_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  accumulator;
    logic [7:0]  x_index;
    logic [7:0]  y_index;
    logic [7:0]  stack_pointer;
    logic [7:0]  status;
    logic        write_enable;
    logic [7:0]  write_data;
    logic        interrupt_taken;
  } cpu_state_t;

  // Directed row: request plus an optional typed-in expectation.
  typedef struct {
    cpu_req_t   req;
    bit         has_exp;
    cpu_state_t exp;
  } dir_row_t;

  // Shadow of the core's architectural state.
  logic [7:0]  sh_a, sh_x, sh_y, sh_sp, sh_p;
  logic        sh_irq_delay;
  logic [7:0]  sh_stack [256];
  logic [15:0] sh_irq_vec, sh_nmi_vec;

  cpu_state_t exp_results [$];
  int         mismatches;
  int         idle_cycles;
  bit         recv_hold;     // long receiver hold-off requested
  bit         recv_random;   // receiver throttling enabled

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void shadow_reset();
    sh_a = '0; sh_x = '0; sh_y = '0;
    sh_sp = SP_RESET; sh_p = FLAGS_RESET; sh_irq_delay = 1'b0;
    foreach (sh_stack[i]) sh_stack[i] = '0;
    sh_irq_vec = '0; sh_nmi_vec = '0;
  endfunction

  function automatic void push8(input logic [7:0] v);
    sh_stack[sh_sp] = v;
    sh_sp = sh_sp - 8'd1;
  endfunction

  function automatic logic [7:0] pull8();
    sh_sp = sh_sp + 8'd1;
    return sh_stack[sh_sp];
  endfunction

  function automatic void nz(input logic [7:0] v);
    sh_p[7] = v[7];
    sh_p[1] = (v == 8'h00);
  endfunction

  function automatic logic [7:0] shift_flags(input logic [1:0] kind, input logic [7:0] v);
    logic [7:0] r;
    logic       co;
    co = (kind == SH_ASL || kind == SH_ROL) ? v[7] : v[0];
    case (kind)
      SH_ASL:  r = v << 1;
      SH_ROL:  r = {v[6:0], sh_p[0]};
      SH_LSR:  r = v >> 1;
      default: r = {sh_p[0], v[7:1]};
    endcase
    sh_p[0] = co;
    nz(r);
    return r;
  endfunction

  function automatic void add_acc(input logic [7:0] v);
    logic [8:0] sum;
    sum = {1'b0, sh_a} + {1'b0, v} + {8'd0, sh_p[0]};
    sh_p[0] = sum[8];
    sh_p[6] = (sh_a[7] ^ sum[7]) & (v[7] ^ sum[7]);
    sh_a = sum[7:0];
    nz(sh_a);
  endfunction

  function automatic void cmp_reg(input logic [7:0] r, input logic [7:0] v);
    sh_p[0] = (r >= v);
    nz(r - v);
  endfunction

  function automatic void change_i(input logic nv, input logic line);
    if (sh_p[2] != nv) begin
      sh_p[2] = nv;
      sh_irq_delay = line;
    end
  endfunction

  // Opcode classes, written out independently of the core's decoder.
  function automatic cls_e classify(input logic [7:0] o);
    logic [2:0] aaa, bbb;
    aaa = o[7:5]; bbb = o[4:2];
    if (o[1:0] == 2'b01) begin
      if (o == 8'h89) return C_NOP;
      case (aaa)
        3'd0: return C_ORA;
        3'd1: return C_AND;
        3'd2: return C_EOR;
        3'd3: return C_ADC;
        3'd4: return C_STA;
        3'd5: return C_LDA;
        3'd6: return C_CMP;
        default: return C_SBC;
      endcase
    end
    if (o[1:0] == 2'b10) begin
      if (bbb == 3'd2) begin
        case (aaa)
          3'd0: return C_ASA;
          3'd1: return C_ROA;
          3'd2: return C_LSA;
          3'd3: return C_RRA;
          3'd4: return C_TXA;
          3'd5: return C_TAX;
          3'd6: return C_DEX;
          default: return C_NOP;
        endcase
      end
      if (bbb == 3'd6) return (aaa == 3'd4) ? C_TXS : (aaa == 3'd5) ? C_TSX : C_NOP;
      if (bbb == 3'd4 || (bbb == 3'd0 && aaa != 3'd5)) return C_NOP;
      if (aaa == 3'd4 && bbb == 3'd7) return C_NOP;
      case (aaa)
        3'd0: return C_ASL;
        3'd1: return C_ROL;
        3'd2: return C_LSR;
        3'd3: return C_ROR;
        3'd4: return C_STX;
        3'd5: return C_LDX;
        3'd6: return C_DEC;
        default: return C_INC;
      endcase
    end
    if (o[1:0] == 2'b11) return C_NOP;
    // cc == 00
    if (bbb == 3'd4) begin
      case (aaa)
        3'd0: return C_BPL;
        3'd1: return C_BMI;
        3'd2: return C_BVC;
        3'd3: return C_BVS;
        3'd4: return C_BCC;
        3'd5: return C_BCS;
        3'd6: return C_BNE;
        default: return C_BEQ;
      endcase
    end
    if (bbb == 3'd6) begin
      case (aaa)
        3'd0: return C_CLC;
        3'd1: return C_SEC;
        3'd2: return C_CLI;
        3'd3: return C_SEI;
        3'd4: return C_TYA;
        3'd5: return C_CLV;
        3'd6: return C_CLD;
        default: return C_SED;
      endcase
    end
    if (bbb == 3'd2) begin
      case (aaa)
        3'd0: return C_PHP;
        3'd1: return C_PLP;
        3'd2: return C_PHA;
        3'd3: return C_PLA;
        3'd4: return C_DEY;
        3'd5: return C_TAY;
        3'd6: return C_INY;
        default: return C_INX;
      endcase
    end
    if (bbb == 3'd0) begin
      case (aaa)
        3'd0: return C_BRK;
        3'd1: return C_JSR;
        3'd2: return C_RTI;
        3'd3: return C_RTS;
        3'd5: return C_LDY;
        3'd6: return C_CPY;
        3'd7: return C_CPX;
        default: return C_NOP;
      endcase
    end
    // bbb 1, 3, 5, 7
    case (aaa)
      3'd1: return (bbb == 3'd1 || bbb == 3'd3) ? C_BIT : C_NOP;
      3'd2: return (bbb == 3'd3) ? C_JMP : C_NOP;
      3'd3: return (bbb == 3'd3) ? C_JMP : C_NOP;
      3'd4: return (bbb == 3'd7) ? C_NOP : C_STY;
      3'd5: return C_LDY;
      3'd6: return (bbb == 3'd1 || bbb == 3'd3) ? C_CPY : C_NOP;
      3'd7: return (bbb == 3'd1 || bbb == 3'd3) ? C_CPX : C_NOP;
      default: return C_NOP;
    endcase
  endfunction

  // Advance the shadow by one request and return the result it must produce.
  function automatic cpu_state_t predict_execute(input cpu_req_t rq);
    cpu_state_t r;
    logic [15:0] t;
    logic [7:0]  lo, nf;
    r = '0;
    r.pc = rq.next_pc;
    if (rq.operation == OP_NMI) begin
      push8(rq.next_pc[15:8]); push8(rq.next_pc[7:0]); push8(sh_p);
      sh_p[2] = 1'b1;
      r.pc = sh_nmi_vec;
      r.interrupt_taken = 1'b1;
      sh_irq_delay = 1'b0;
    end else if (rq.operation == OP_IRQ) begin
      // IRQ is seen one instruction late after an I change
      if (sh_irq_delay == sh_p[2]) begin
        push8(rq.next_pc[15:8]); push8(rq.next_pc[7:0]); push8(sh_p);
        sh_p[2] = 1'b1;
        r.pc = sh_irq_vec;
        r.interrupt_taken = 1'b1;
      end
      sh_irq_delay = 1'b0;
    end else if (rq.operation == OP_EXEC) begin
      sh_irq_delay = 1'b0;
      case (classify(rq.opcode))
        C_ADC: add_acc(rq.operand);
        C_SBC: add_acc(~rq.operand);
        C_AND: begin sh_a &= rq.operand; nz(sh_a); end
        C_ORA: begin sh_a |= rq.operand; nz(sh_a); end
        C_EOR: begin sh_a ^= rq.operand; nz(sh_a); end
        C_ASL: begin r.write_data = shift_flags(SH_ASL, rq.operand); r.write_enable = 1; end
        C_LSR: begin r.write_data = shift_flags(SH_LSR, rq.operand); r.write_enable = 1; end
        C_ROL: begin r.write_data = shift_flags(SH_ROL, rq.operand); r.write_enable = 1; end
        C_ROR: begin r.write_data = shift_flags(SH_ROR, rq.operand); r.write_enable = 1; end
        C_ASA: sh_a = shift_flags(SH_ASL, sh_a);
        C_LSA: sh_a = shift_flags(SH_LSR, sh_a);
        C_ROA: sh_a = shift_flags(SH_ROL, sh_a);
        C_RRA: sh_a = shift_flags(SH_ROR, sh_a);
        C_BIT: begin
          sh_p[7:6] = rq.operand[7:6];
          sh_p[1] = ((sh_a & rq.operand) == 8'h00);
        end
        C_BCC: if (!sh_p[0]) r.pc = rq.target_address;
        C_BCS: if (sh_p[0]) r.pc = rq.target_address;
        C_BNE: if (!sh_p[1]) r.pc = rq.target_address;
        C_BEQ: if (sh_p[1]) r.pc = rq.target_address;
        C_BVC: if (!sh_p[6]) r.pc = rq.target_address;
        C_BVS: if (sh_p[6]) r.pc = rq.target_address;
        C_BPL: if (!sh_p[7]) r.pc = rq.target_address;
        C_BMI: if (sh_p[7]) r.pc = rq.target_address;
        C_BRK: begin
          t = rq.next_pc + 16'd1;
          push8(t[15:8]); push8(t[7:0]); push8(sh_p | PUSH_BITS);
          r.pc = sh_irq_vec;
          sh_p[2] = 1'b1;
        end
        C_CLC: sh_p[0] = 1'b0;
        C_SEC: sh_p[0] = 1'b1;
        C_CLD: sh_p[3] = 1'b0;
        C_SED: sh_p[3] = 1'b1;
        C_CLV: sh_p[6] = 1'b0;
        C_CLI: change_i(1'b0, rq.irq_line);
        C_SEI: change_i(1'b1, rq.irq_line);
        C_CMP: cmp_reg(sh_a, rq.operand);
        C_CPX: cmp_reg(sh_x, rq.operand);
        C_CPY: cmp_reg(sh_y, rq.operand);
        C_DEC: begin r.write_data = rq.operand - 8'd1; r.write_enable = 1; nz(r.write_data); end
        C_INC: begin r.write_data = rq.operand + 8'd1; r.write_enable = 1; nz(r.write_data); end
        C_DEX: begin sh_x -= 8'd1; nz(sh_x); end
        C_DEY: begin sh_y -= 8'd1; nz(sh_y); end
        C_INX: begin sh_x += 8'd1; nz(sh_x); end
        C_INY: begin sh_y += 8'd1; nz(sh_y); end
        C_JMP: r.pc = rq.target_address;
        C_JSR: begin
          t = rq.next_pc - 16'd1;
          push8(t[15:8]); push8(t[7:0]);
          r.pc = rq.target_address;
        end
        C_RTS: begin
          lo = pull8();
          t = {pull8(), lo};
          r.pc = t + 16'd1;
        end
        C_RTI: begin
          sh_p = pull8() | ONE_BIT;
          lo = pull8();
          r.pc = {pull8(), lo};
        end
        C_LDA: begin sh_a = rq.operand; nz(sh_a); end
        C_LDX: begin sh_x = rq.operand; nz(sh_x); end
        C_LDY: begin sh_y = rq.operand; nz(sh_y); end
        C_PHA: push8(sh_a);
        C_PHP: push8(sh_p | PUSH_BITS);
        C_PLA: begin sh_a = pull8(); nz(sh_a); end
        C_PLP: begin
          nf = pull8() | ONE_BIT;
          if (nf[2] != sh_p[2]) sh_irq_delay = rq.irq_line;
          sh_p = nf;
        end
        C_STA: begin r.write_data = sh_a; r.write_enable = 1; end
        C_STX: begin r.write_data = sh_x; r.write_enable = 1; end
        C_STY: begin r.write_data = sh_y; r.write_enable = 1; end
        C_TAX: begin sh_x = sh_a; nz(sh_x); end
        C_TAY: begin sh_y = sh_a; nz(sh_y); end
        C_TSX: begin sh_x = sh_sp; nz(sh_x); end
        C_TXA: begin sh_a = sh_x; nz(sh_a); end
        C_TYA: begin sh_a = sh_y; nz(sh_a); end
        C_TXS: sh_sp = sh_x;
        default: ;
      endcase
    end
    r.accumulator   = sh_a;
    r.x_index       = sh_x;
    r.y_index       = sh_y;
    r.stack_pointer = sh_sp;
    r.status        = sh_p;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: throttle ready, compare every accepted result with the oldest
  // expectation. Sampling happens at the edge, before the NBA updates land.
  // ---------------------------------------------------------------------------
  int hold_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_o.ready <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (recv_hold) begin
        // long stall: the core must fill up and push back on requests
        rsp_o.ready <= 1'b0;
      end else if (hold_left > 0) begin
        rsp_o.ready <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (recv_random && $urandom_range(0, 3) == 0) begin
        rsp_o.ready <= 1'b0;
        hold_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 2);
      end else begin
        rsp_o.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cpu_state_t got, want;
    if (rst_ni && rsp_o.valid && rsp_o.ready) begin
      got = '{rsp_o.pc, rsp_o.accumulator, rsp_o.x_index, rsp_o.y_index,
              rsp_o.stack_pointer, rsp_o.status, rsp_o.write_enable,
              rsp_o.write_data, rsp_o.interrupt_taken};
      if (exp_results.size() == 0) begin
        $display("ERROR %0t: result with nothing expected", $realtime);
        mismatches++;
      end else begin
        want = exp_results.pop_front();
        if (got.pc != want.pc) report_mismatch("pc", got.pc, want.pc);
        if (got.accumulator != want.accumulator)
          report_mismatch("accumulator", got.accumulator, want.accumulator);
        if (got.x_index != want.x_index) report_mismatch("x_index", got.x_index, want.x_index);
        if (got.y_index != want.y_index) report_mismatch("y_index", got.y_index, want.y_index);
        if (got.stack_pointer != want.stack_pointer)
          report_mismatch("stack_pointer", got.stack_pointer, want.stack_pointer);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.write_enable != want.write_enable)
          report_mismatch("write_enable", got.write_enable, want.write_enable);
        if (got.write_data != want.write_data)
          report_mismatch("write_data", got.write_data, want.write_data);
        if (got.interrupt_taken != want.interrupt_taken)
          report_mismatch("interrupt_taken", got.interrupt_taken, want.interrupt_taken);
      end
    end
  end

  // Watchdog: cycles with no request and no result accepted, outside a long receiver hold.
  always @(posedge clk_i) begin
    if ((req_i.valid && req_i.ready) || (rsp_o.valid && rsp_o.ready) || recv_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side helpers
  // ---------------------------------------------------------------------------
  // Drive one request and hold it until accepted; the shadow advances at
  // acceptance. Valid stays high into the next request when no gap follows.
  task automatic send_request(input cpu_req_t rq, input bit has_exp, input cpu_state_t ex);
    cpu_state_t pred;
    int gap;
    req_i.valid          <= 1'b1;
    req_i.operation      <= rq.operation;
    req_i.opcode         <= rq.opcode;
    req_i.operand        <= rq.operand;
    req_i.target_address <= rq.target_address;
    req_i.next_pc        <= rq.next_pc;
    req_i.irq_line       <= rq.irq_line;
    do @(posedge clk_i); while (!req_i.ready);
    pred = predict_execute(rq);
    if (has_exp && pred != ex)
      $display("NOTE %0t: directed row disagrees with predictor", $realtime);
    exp_results.push_back(has_exp ? ex : pred);
    gap = 0;
    if (recv_random && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 25) : $urandom_range(1, 3);
    if (gap > 0) begin
      req_i.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    req_i.valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vector(input logic idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_IRQ_VEC) sh_irq_vec = val;
    else sh_nmi_vec = val;
  endtask

  function automatic cpu_req_t mk_req(input logic [1:0] op, input logic [7:0] opc,
                                      input logic [7:0] v, input logic [15:0] ta,
                                      input logic [15:0] np, input logic line);
    cpu_req_t r;
    r = '{op, opc, v, ta, np, line};
    return r;
  endfunction

  // Random opcode drawn mostly from a pool of useful ones, weighted toward
  // balanced push/pull so stack contents are exercised without wandering.
  function automatic logic [7:0] pick_opcode();
    logic [7:0] pool [32] = '{8'h69, 8'hE9, 8'h29, 8'h09, 8'h49, 8'hC9, 8'hE0, 8'hC0,
                              8'hA9, 8'hA2, 8'hA0, 8'h85, 8'h86, 8'h84, 8'h06, 8'h26,
                              8'h46, 8'h66, 8'h0A, 8'h2A, 8'h4A, 8'h6A, 8'hC6, 8'hE6,
                              8'hCA, 8'h88, 8'hE8, 8'hC8, 8'h24, 8'hAA, 8'h8A, 8'hBA};
    logic [7:0] flow [24] = '{8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0,
                              8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8, 8'h4C,
                              8'h48, 8'h68, 8'h08, 8'h28, 8'h20, 8'h60, 8'h40, 8'h9A};
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return pool[$urandom_range(0, 31)];
    if (k < 8) return flow[$urandom_range(0, 23)];
    if (k == 8) return 8'h00;
    return $urandom_range(0, 255);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  localparam int N_DIR = 22;
  dir_row_t dir_tab [N_DIR];
  int       n_taken;

  initial begin
    cpu_state_t nil;
    cpu_req_t   rq;
    logic [1:0] op;
    nil = '0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = 1'b0;
    cfg_data_i   = '0;
    req_i.valid  = 1'b0;
    req_i.operation = OP_EXEC;
    req_i.opcode = '0; req_i.operand = '0; req_i.target_address = '0;
    req_i.next_pc = '0; req_i.irq_line = 1'b0;
    recv_hold    = 1'b0;
    recv_random  = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    shadow_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed expectations only where obvious: reset state,
    // extremes, undefined operation code.
    dir_tab[0]  = '{mk_req(OP_EXEC, 8'hEA, 8'h00, 16'h0000, 16'h0001, 0), 1,
                    '{16'h0001, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h34, 0, 8'h00, 0}};
    dir_tab[1]  = '{mk_req(2'd3, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1), 1,
                    '{16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h34, 0, 8'h00, 0}};
    dir_tab[2]  = '{mk_req(OP_EXEC, 8'hA9, 8'hFF, 16'hFFFF, 16'h0002, 0), 1,
                    '{16'h0002, 8'hFF, 8'h00, 8'h00, 8'hFD, 8'hB4, 0, 8'h00, 0}};
    dir_tab[3]  = '{mk_req(OP_EXEC, 8'h69, 8'h01, 16'h0000, 16'h0004, 0), 0, nil}; // carry out
    dir_tab[4]  = '{mk_req(OP_EXEC, 8'hA9, 8'h7F, 16'h0000, 16'h0006, 0), 0, nil};
    dir_tab[5]  = '{mk_req(OP_EXEC, 8'h69, 8'h01, 16'h0000, 16'h0008, 0), 0, nil}; // overflow
    dir_tab[6]  = '{mk_req(OP_EXEC, 8'hE9, 8'hFF, 16'h0000, 16'h000A, 0), 0, nil};
    dir_tab[7]  = '{mk_req(OP_EXEC, 8'h85, 8'h00, 16'h01FF, 16'h000C, 0), 0, nil}; // store to page 1
    dir_tab[8]  = '{mk_req(OP_EXEC, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 0), 0, nil}; // BRK wrap
    dir_tab[9]  = '{mk_req(OP_EXEC, 8'h40, 8'h00, 16'h0000, 16'h1234, 0), 0, nil}; // RTI
    dir_tab[10] = '{mk_req(OP_EXEC, 8'h20, 8'h00, 16'hABCD, 16'h0000, 0), 0, nil}; // JSR wrap
    dir_tab[11] = '{mk_req(OP_EXEC, 8'h60, 8'h00, 16'h0000, 16'h5555, 0), 0, nil}; // RTS
    dir_tab[12] = '{mk_req(OP_EXEC, 8'h58, 8'h00, 16'h0000, 16'h0010, 1), 0, nil}; // CLI, line high
    dir_tab[13] = '{mk_req(OP_IRQ,  8'h00, 8'h00, 16'h0000, 16'h0020, 1), 0, nil}; // late by one
    dir_tab[14] = '{mk_req(OP_IRQ,  8'h00, 8'h00, 16'h0000, 16'h0030, 1), 0, nil}; // now taken
    dir_tab[15] = '{mk_req(OP_NMI,  8'h00, 8'h00, 16'h0000, 16'h8000, 0), 0, nil};
    dir_tab[16] = '{mk_req(OP_EXEC, 8'h28, 8'h00, 16'h0000, 16'h0040, 1), 0, nil}; // PLP
    dir_tab[17] = '{mk_req(OP_EXEC, 8'hA2, 8'h00, 16'h0000, 16'h0042, 0), 0, nil};
    dir_tab[18] = '{mk_req(OP_EXEC, 8'h9A, 8'h00, 16'h0000, 16'h0043, 0), 0, nil}; // TXS to 0
    dir_tab[19] = '{mk_req(OP_EXEC, 8'h48, 8'h00, 16'h0000, 16'h0044, 0), 0, nil}; // push wraps sp
    dir_tab[20] = '{mk_req(OP_EXEC, 8'h68, 8'h00, 16'h0000, 16'h0045, 0), 0, nil};
    dir_tab[21] = '{mk_req(OP_EXEC, 8'hF8, 8'h00, 16'h0000, 16'h0046, 0), 0, nil}; // SED

    write_vector(CFG_IRQ_VEC, 16'hFFFF);
    write_vector(CFG_NMI_VEC, 16'h0000);
    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].exp);
    drain_and_settle();

    // Random phases with different vectors; receiver now throttles at random.
    recv_random = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      write_vector(CFG_IRQ_VEC, (phase == 0) ? 16'h0000 : 16'($urandom_range(0, 65535)));
      write_vector(CFG_NMI_VEC, (phase == 3) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
      if (phase == 1) begin
        // long receiver stall while requests keep coming
        fork
          begin
            recv_hold = 1'b1;
            repeat (60) @(posedge clk_i);
            recv_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 100; n++) begin
        n_taken = $urandom_range(0, 19);
        op = (n_taken == 0) ? OP_NMI : (n_taken < 3) ? OP_IRQ
           : (n_taken == 3) ? 2'd3 : OP_EXEC;
        rq = mk_req(op, pick_opcode(), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)));
        send_request(rq, 1'b0, nil);
      end
      drain_and_settle();
    end

    if (mismatches == 0 && exp_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cie_pkg.sv
rtl/cie_req_if.sv
rtl/cie_rsp_if.sv
rtl/cpu_instruction_execute_core.sv
sim/tb_top.sv
